// File: hdl/bpm_pkg.sv
package bpm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_PATTERN_LEN = 2'd1;
  localparam logic [1:0] REG_PATTERN_LO  = 2'd2;
  localparam logic [1:0] REG_PATTERN_HI  = 2'd3;

  // Search modes
  localparam logic [1:0] MODE_PREFIX = 2'd0;
  localparam logic [1:0] MODE_SUFFIX = 2'd1;
  localparam logic [1:0] MODE_INDEX  = 2'd2;
  localparam logic [1:0] MODE_COUNT  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_W     = 5;
  localparam int POS_W      = 16;
  localparam int CNT_W      = 17;
  localparam int PAT_BYTES  = 16;

  // UTF-8 lead byte masks and tags
  localparam logic [7:0] UTF_MASK1 = 8'h80;
  localparam logic [7:0] UTF_MASK2 = 8'hE0;
  localparam logic [7:0] UTF_TAG2  = 8'hC0;
  localparam logic [7:0] UTF_MASK3 = 8'hF0;
  localparam logic [7:0] UTF_TAG3  = 8'hE0;
  localparam logic [7:0] UTF_MASK4 = 8'hF8;
  localparam logic [7:0] UTF_TAG4  = 8'hF0;

  // Per-cycle control shared by the whole cell row
  typedef struct packed {
    logic advance;   // compare against the shifted window
    logic shift_en;  // window shifts this cycle
    logic clear;     // drop all start marks
  } cell_ctrl_t;

  // Character length from a lead byte: 1..4, 0 when invalid
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if ((b & UTF_MASK1) == 8'h00) begin
      n = 3'd1;
    end else if ((b & UTF_MASK2) == UTF_TAG2) begin
      n = 3'd2;
    end else if ((b & UTF_MASK3) == UTF_TAG3) begin
      n = 3'd3;
    end else if ((b & UTF_MASK4) == UTF_TAG4) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

endpackage

// File: hdl/bpm_cell.sv
// One window slot: holds a byte and its boundary mark, compares against
// its pattern byte.
module bpm_cell
  import bpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] byte_in,
  input  logic       mark_in,
  input  logic [7:0] pat_byte,
  input  logic       use_en,
  output logic [7:0] byte_out,
  output logic       mark_out,
  output logic       mark_view,
  output logic       eq
);

  logic [7:0] byte_r;
  logic       mark_r;
  logic [7:0] byte_view;

  assign byte_view = ctrl.advance ? byte_in : byte_r;
  assign mark_view = ctrl.advance ? mark_in : mark_r;
  assign eq        = !use_en || (byte_view == pat_byte);
  assign byte_out  = byte_r;
  assign mark_out  = mark_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else if (ctrl.shift_en) begin
      byte_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      mark_r <= 1'b0;
    end else if (ctrl.shift_en) begin
      mark_r <= mark_in;
    end
  end

endmodule

// File: hdl/byte_pattern_matcher.sv
// Channel   Direction  Transaction payload
// --------  ---------  -----------------------------------------------------
// in_       input      data_byte, last: one string byte
// out_      output     found, position, match_count, empty_pattern, too_long
// cfg_      input      index, data: configuration register write
//
// One byte per cycle while in_ready is high. The result register loads on
// the cycle a byte with last set is taken and shows the result in the
// following cycle; it holds until taken, while in_ready stays high as long
// as the result register is free or is being emptied in the same cycle.
// The cycle time is set by the row of window cells: all PATTERN_MAX byte
// compares and their AND are combinational. rst_n is synchronous; config
// and all per-string state take their reset values. cfg_ready is always high.
module byte_pattern_matcher
  import bpm_pkg::*;
#(
  parameter int PATTERN_MAX = 16,
  parameter int STRING_MAX  = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [POS_W-1:0]      out_position,
  output logic [CNT_W-1:0]      out_match_count,
  output logic                  out_empty_pattern,
  output logic                  out_too_long,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Offset counter reaches STRING_MAX itself; EXT_W leaves room for +1
  // and for the 16-bit position saturation compare.
  localparam int OFF_W = $clog2(STRING_MAX + 1);
  localparam int EXT_W = (OFF_W > POS_W + 1) ? OFF_W + 1 : POS_W + 2;

  // ---------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------
  logic [1:0]            mode_r;
  logic [PLEN_W-1:0]     plen_r;
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_INDEX;
      plen_r   <= '0;
      pat_lo_r <= '0;
      pat_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:        mode_r   <= cfg_data[1:0];
        REG_PATTERN_LEN: plen_r   <= cfg_data[PLEN_W-1:0];
        REG_PATTERN_LO:  pat_lo_r <= cfg_data;
        REG_PATTERN_HI:  pat_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pattern length clamped to the cell count
  logic [PLEN_W-1:0]          len_c;
  logic [8*PAT_BYTES-1:0]     pat_all;

  assign len_c   = (plen_r > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen_r;
  assign pat_all = {pat_hi_r, pat_lo_r};

  // ---------------------------------------------------------------
  // Per-string state
  // ---------------------------------------------------------------
  logic [OFF_W-1:0] offset_r;
  logic [1:0]       cbl_r;        // continuation bytes left in current char
  logic             blocked_r;    // invalid lead seen: no new starts
  logic             first_found_r;
  logic [POS_W-1:0] first_pos_r;
  logic [CNT_W-1:0] count_r;
  logic             overflow_r;

  logic in_acc;
  logic active;     // byte is inside the length limit
  logic out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign active   = !overflow_r && (EXT_W'(offset_r) < EXT_W'(STRING_MAX));

  logic [EXT_W-1:0] pos1;       // offset after this byte
  logic [EXT_W-1:0] off_after;
  logic [EXT_W-1:0] start_pos;

  assign pos1      = EXT_W'(offset_r) + EXT_W'(1);
  assign off_after = active ? pos1 : EXT_W'(offset_r);
  assign start_pos = pos1 - EXT_W'(len_c);

  // ---------------------------------------------------------------
  // Cell row: cell i holds window slot i (newest at 0)
  // ---------------------------------------------------------------
  cell_ctrl_t           cell_ctrl;
  logic [7:0]           win_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] win_mark;
  logic [PATTERN_MAX-1:0] view_mark;
  logic [PATTERN_MAX-1:0] eq_vec;
  logic                 new_mark;
  logic                 count_hit;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic [PLEN_W-1:0] pidx;
      logic [7:0]        chain_byte;
      logic              chain_mark;

      // slot i lines up with pattern byte len-1-i
      assign pidx = len_c - PLEN_W'(1) - PLEN_W'(gi);

      if (gi == 0) begin : g_head
        assign chain_byte = in_data_byte;
        assign chain_mark = new_mark;
      end else begin : g_body
        assign chain_byte = win_byte[gi-1];
        assign chain_mark = win_mark[gi-1];
      end

      bpm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .byte_in   (chain_byte),
        .mark_in   (chain_mark),
        .pat_byte  (pat_all[8*pidx[3:0] +: 8]),
        .use_en    (PLEN_W'(gi) < len_c),
        .byte_out  (win_byte[gi]),
        .mark_out  (win_mark[gi]),
        .mark_view (view_mark[gi]),
        .eq        (eq_vec[gi])
      );
    end
  endgenerate

  logic all_eq;
  logic match;
  logic cand;     // window start slot is a char boundary

  assign all_eq = &eq_vec;
  assign match  = active && (len_c != '0) && (pos1 >= EXT_W'(len_c)) && all_eq;

  always_comb begin
    cand = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (len_c == PLEN_W'(i + 1)) begin
        cand = view_mark[i];
      end
    end
  end

  // ---------------------------------------------------------------
  // Step logic: UTF-8 boundary tracking and match bookkeeping
  // ---------------------------------------------------------------
  logic [2:0]       lead;
  logic [1:0]       cbl_step;
  logic             blk_step;
  logic             ff_step;
  logic [POS_W-1:0] fp_step;
  logic [CNT_W-1:0] cnt_step;

  assign lead = lead_length(in_data_byte);

  always_comb begin
    new_mark  = 1'b0;
    cbl_step  = cbl_r;
    blk_step  = blocked_r;
    ff_step   = first_found_r;
    fp_step   = first_pos_r;
    cnt_step  = count_r;
    count_hit = 1'b0;

    if (active) begin
      if (cbl_r == 2'd0) begin
        if (!blocked_r) begin
          if (lead == 3'd0) begin
            blk_step = 1'b1;
          end else begin
            new_mark = 1'b1;
            cbl_step = 2'(lead - 3'd1);
          end
        end
      end else begin
        cbl_step = cbl_r - 2'd1;
      end
    end

    if (match) begin
      case (mode_r)
        MODE_PREFIX: begin
          if (pos1 == EXT_W'(len_c)) begin
            ff_step = 1'b1;
          end
        end
        MODE_INDEX: begin
          if (cand && !first_found_r) begin
            ff_step = 1'b1;
            fp_step = (start_pos > EXT_W'({POS_W{1'b1}})) ? {POS_W{1'b1}}
                                                          : start_pos[POS_W-1:0];
          end
        end
        MODE_COUNT: begin
          if (cand) begin
            // restart the search right after this match
            count_hit = 1'b1;
            if (count_r != {CNT_W{1'b1}}) begin
              cnt_step = count_r + CNT_W'(1);
            end
            cbl_step = 2'd0;
            blk_step = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cell_ctrl.advance  = active;
  assign cell_ctrl.shift_en = in_acc && active;
  assign cell_ctrl.clear    = in_acc && (in_last || count_hit);

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_last)) begin
      offset_r      <= '0;
      cbl_r         <= 2'd0;
      blocked_r     <= 1'b0;
      first_found_r <= 1'b0;
      first_pos_r   <= '0;
      count_r       <= '0;
      overflow_r    <= 1'b0;
    end else if (in_acc) begin
      if (active) begin
        offset_r      <= pos1[OFF_W-1:0];
        cbl_r         <= cbl_step;
        blocked_r     <= blk_step;
        first_found_r <= ff_step;
        first_pos_r   <= fp_step;
        count_r       <= cnt_step;
      end else begin
        overflow_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Result formation and output register
  // ---------------------------------------------------------------
  logic             res_found;
  logic [POS_W-1:0] res_pos;
  logic [CNT_W-1:0] res_cnt;

  always_comb begin
    res_found = 1'b0;
    res_pos   = '0;
    res_cnt   = '0;
    if (len_c != '0) begin
      case (mode_r)
        MODE_PREFIX: res_found = ff_step;
        MODE_SUFFIX: res_found = (off_after >= EXT_W'(len_c)) && all_eq;
        MODE_INDEX: begin
          res_found = ff_step;
          res_pos   = ff_step ? fp_step : '0;
        end
        default: begin
          res_cnt   = cnt_step;
          res_found = (cnt_step != '0);
        end
      endcase
    end
  end

  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic [CNT_W-1:0] out_match_count_r;
  logic             out_empty_r;
  logic             out_too_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last) begin
      out_found_r       <= res_found;
      out_position_r    <= res_pos;
      out_match_count_r <= res_cnt;
      out_empty_r       <= (len_c == '0);
      out_too_long_r    <= !active;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_position      = out_position_r;
  assign out_match_count   = out_match_count_r;
  assign out_empty_pattern = out_empty_r;
  assign out_too_long      = out_too_long_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // A blocked search never sits inside a multi-byte character
  a_block_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    blocked_r |-> (cbl_r == 2'd0))
    else $error("starts blocked while inside a character");

  // The length limit flag is set only once the offset counter is full
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> (EXT_W'(offset_r) == EXT_W'(STRING_MAX)))
    else $error("overflow without full offset");

  // An empty pattern never reports a hit
  a_empty_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (!out_found_r && (out_match_count_r == '0)))
    else $error("empty pattern reported a match");

  // Closing a string clears all boundary marks and the offset counter
  a_marks_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (win_mark == '0) && (offset_r == '0))
    else $error("per-string state not cleared");

endmodule
